// ----- rtl/tcw_pkg.sv -----
`default_nettype none

package tcw_pkg;

    // command codes of an input word
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_FG  = 2'd0;
    localparam logic [1:0] CFG_BG  = 2'd1;
    localparam logic [1:0] CFG_TAB = 2'd2;

    // colour codes and register reset values
    localparam logic [3:0] BG_DEFAULT  = 4'd0;
    localparam logic [3:0] FG_DEFAULT  = 4'd7;
    localparam logic [4:0] TAB_DEFAULT = 5'd4;

    // character codes with a meaning of their own
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_SHIFT_IN  = 8'h0F;
    localparam logic [7:0] CH_GRAVE     = 8'h60;
    localparam logic [7:0] CH_TILDE     = 8'h7E;
    localparam logic [7:0] CH_BLANK     = 8'h20;

    // datapath commands issued by the controller
    typedef struct packed {
        logic latch;        // capture the input word
        logic wr_cell;      // write at the cursor
        logic wr_blank;     // written character is a blank
        logic advance;      // step the cursor one cell
        logic newline;      // column 0 of the next row
        logic col_home;     // column 0 of the same row
        logic back;         // one column left
        logic tab_load;     // load the tab counter
        logic tab_dec;      // count one tab blank
        logic scroll_step;  // blank one cell of the scrolled-out row
        logic sweep_step;   // blank one cell of the whole store
        logic sweep_boot;   // sweep uses the reset colours
        logic rd_cell;      // read the requested cell
        logic load_out;     // load the result register
    } tcw_ctl_t;

    // datapath status seen by the controller
    typedef struct packed {
        logic is_put;
        logic is_clear;
        logic is_read;
        logic is_nl;
        logic is_cr;
        logic is_tab;
        logic is_bs;
        logic is_hook;
        logic col_zero;
        logic last_row;
        logic last_col;
        logic tab_more;
        logic sweep_last;
        logic scroll_last;
    } tcw_stat_t;

endpackage

`default_nettype wire

// ----- rtl/tcw_ctrl.sv -----
`default_nettype none

module tcw_ctrl
    import tcw_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  wire logic      out_stall,
    input  wire tcw_stat_t stat,
    output tcw_ctl_t       ctl
);

    localparam logic [3:0] S_BOOT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DISP   = 4'd2;
    localparam logic [3:0] S_CLEAR  = 4'd3;
    localparam logic [3:0] S_READ   = 4'd4;
    localparam logic [3:0] S_BS_WR  = 4'd5;
    localparam logic [3:0] S_TAB    = 4'd6;
    localparam logic [3:0] S_SCROLL = 4'd7;
    localparam logic [3:0] S_FINISH = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       ret_tab_reg;
    logic       ret_tab_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // next state and datapath commands
    always_comb
    begin
        ctl            = '0;
        state_next     = state_reg;
        ret_tab_next   = ret_tab_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_BOOT:
            begin
                ctl.sweep_step = 1'b1;
                ctl.sweep_boot = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.latch  = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (stat.is_clear)
                begin
                    state_next = S_CLEAR;
                end
                else if (stat.is_read)
                begin
                    state_next = S_READ;
                end
                else if (stat.is_put)
                begin
                    ctl.tab_load = 1'b1;
                    ret_tab_next = 1'b0;
                    if (stat.is_nl)
                    begin
                        ctl.newline = 1'b1;
                        state_next  = stat.last_row ? S_SCROLL : S_FINISH;
                    end
                    else if (stat.is_cr)
                    begin
                        ctl.col_home = 1'b1;
                        state_next   = S_FINISH;
                    end
                    else if (stat.is_tab)
                    begin
                        state_next = S_TAB;
                    end
                    else if (stat.is_bs)
                    begin
                        if (!stat.col_zero)
                        begin
                            ctl.back   = 1'b1;
                            state_next = S_BS_WR;
                        end
                        else
                        begin
                            state_next = S_FINISH;
                        end
                    end
                    else
                    begin
                        // hook codes only advance, the rest are written first
                        ctl.wr_cell = !stat.is_hook;
                        ctl.advance = 1'b1;
                        state_next  = (stat.last_row && stat.last_col) ? S_SCROLL : S_FINISH;
                    end
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_CLEAR:
            begin
                ctl.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_READ:
            begin
                ctl.rd_cell = 1'b1;
                state_next  = S_FINISH;
            end
            S_BS_WR:
            begin
                ctl.wr_cell  = 1'b1;
                ctl.wr_blank = 1'b1;
                state_next   = S_FINISH;
            end
            S_TAB:
            begin
                // blanks while more than one position is left, then a bare advance
                ctl.advance = 1'b1;
                if (stat.tab_more)
                begin
                    ctl.wr_cell  = 1'b1;
                    ctl.wr_blank = 1'b1;
                    ctl.tab_dec  = 1'b1;
                    ret_tab_next = 1'b1;
                    state_next   = (stat.last_row && stat.last_col) ? S_SCROLL : S_TAB;
                end
                else
                begin
                    ret_tab_next = 1'b0;
                    state_next   = (stat.last_row && stat.last_col) ? S_SCROLL : S_FINISH;
                end
            end
            S_SCROLL:
            begin
                ctl.scroll_step = 1'b1;
                if (stat.scroll_last)
                begin
                    state_next = ret_tab_reg ? S_TAB : S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    ctl.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_BOOT;
            ret_tab_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_tab_reg   <= ret_tab_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- rtl/tcw_datapath.sv -----
`default_nettype none

module tcw_datapath
    import tcw_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [4:0] cfg_data,
    input  wire logic [1:0] command,
    input  wire logic [7:0] char_code,
    input  wire logic       fg_override_on,
    input  wire logic [3:0] fg_override,
    input  wire logic [4:0] read_row,
    input  wire logic [6:0] read_col,
    input  wire tcw_ctl_t   ctl,
    output tcw_stat_t       stat,
    output logic [4:0]      cursor_row,
    output logic [6:0]      cursor_col,
    output logic [7:0]      cell_char,
    output logic [7:0]      cell_attr
);

    localparam int NCELLS = ROWS * COLS;
    localparam int ADDR_W = $clog2(NCELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);
    localparam int SUM_W  = ROW_W + 1;

    // configuration registers
    logic [3:0]       fg_reg;
    logic [3:0]       bg_reg;
    logic [4:0]       tab_reg;

    // captured input word
    logic [1:0]       cmd_reg;
    logic [7:0]       char_reg;
    logic [7:0]       attr_reg;
    logic [ROW_W-1:0] rrow_reg;
    logic [COL_W-1:0] rcol_reg;
    logic             rok_reg;

    // cursor, first displayed row and counters
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  top_reg;
    logic [ADDR_W-1:0] cnt_reg;
    logic [4:0]        tab_cnt_reg;

    // cell store
    logic [15:0]       mem [NCELLS];
    logic [15:0]       rd_data_reg;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       wdata;
    logic              we;
    logic [ROW_W-1:0]  cur_phys;
    logic [ROW_W-1:0]  rd_phys;
    logic [7:0]        clr_attr;

    // result register
    logic [4:0] cursor_row_reg;
    logic [6:0] cursor_col_reg;
    logic [7:0] cell_char_reg;
    logic [7:0] cell_attr_reg;

    // logical row to stored row through the scroll offset
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                  input logic [ROW_W-1:0] t);
        logic [SUM_W-1:0] sum;
        begin
            sum = {1'b0, r} + {1'b0, t};
            if (sum >= SUM_W'(ROWS))
            begin
                phys_row = ROW_W'(sum - SUM_W'(ROWS));
            end
            else
            begin
                phys_row = ROW_W'(sum);
            end
        end
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        begin
            cell_addr = ADDR_W'(r) * ADDR_W'(COLS) + ADDR_W'(c);
        end
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg  <= FG_DEFAULT;
            bg_reg  <= BG_DEFAULT;
            tab_reg <= TAB_DEFAULT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FG:  fg_reg  <= cfg_data[3:0];
                CFG_BG:  bg_reg  <= cfg_data[3:0];
                CFG_TAB: tab_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input word capture
    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            cmd_reg  <= command;
            char_reg <= char_code;
            attr_reg <= {bg_reg, fg_override_on ? fg_override : fg_reg};
            rrow_reg <= ROW_W'(read_row);
            rcol_reg <= COL_W'(read_col);
            rok_reg  <= ({27'd0, read_row} < 32'(ROWS)) && ({25'd0, read_col} < 32'(COLS));
        end
    end

    // cursor, scroll offset and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            col_reg     <= '0;
            top_reg     <= '0;
            cnt_reg     <= '0;
            tab_cnt_reg <= '0;
        end
        else
        begin
            if (ctl.advance)
            begin
                if (col_reg == COL_W'(COLS - 1))
                begin
                    col_reg <= '0;
                    if (row_reg != ROW_W'(ROWS - 1))
                    begin
                        row_reg <= row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            else if (ctl.newline)
            begin
                col_reg <= '0;
                if (row_reg != ROW_W'(ROWS - 1))
                begin
                    row_reg <= row_reg + 1'b1;
                end
            end
            else if (ctl.col_home)
            begin
                col_reg <= '0;
            end
            else if (ctl.back)
            begin
                col_reg <= col_reg - 1'b1;
            end

            if (ctl.tab_load)
            begin
                tab_cnt_reg <= tab_reg;
            end
            else if (ctl.tab_dec)
            begin
                tab_cnt_reg <= tab_cnt_reg - 1'b1;
            end

            // full sweep ends with the cursor home and no scroll offset
            if (ctl.sweep_step)
            begin
                if (stat.sweep_last)
                begin
                    cnt_reg <= '0;
                    row_reg <= '0;
                    col_reg <= '0;
                    top_reg <= '0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            else if (ctl.scroll_step)
            begin
                if (stat.scroll_last)
                begin
                    cnt_reg <= '0;
                    top_reg <= (top_reg == ROW_W'(ROWS - 1)) ? '0 : top_reg + 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    // store address and write data
    always_comb
    begin
        cur_phys = phys_row(row_reg, top_reg);
        rd_phys  = phys_row(rrow_reg, top_reg);
        clr_attr = ctl.sweep_boot ? {BG_DEFAULT, FG_DEFAULT} : {bg_reg, fg_reg};
        if (ctl.sweep_step)
        begin
            addr  = cnt_reg;
            wdata = {clr_attr, CH_BLANK};
            we    = 1'b1;
        end
        else if (ctl.scroll_step)
        begin
            // the row leaving the top becomes the new bottom row
            addr  = cell_addr(top_reg, COL_W'(cnt_reg));
            wdata = {attr_reg, CH_BLANK};
            we    = 1'b1;
        end
        else if (ctl.rd_cell)
        begin
            addr  = cell_addr(rd_phys, rcol_reg);
            wdata = {attr_reg, CH_BLANK};
            we    = 1'b0;
        end
        else
        begin
            addr  = cell_addr(cur_phys, col_reg);
            wdata = {attr_reg, ctl.wr_blank ? CH_BLANK : char_reg};
            we    = ctl.wr_cell;
        end
    end

    // cell store port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.rd_cell && rok_reg)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            cursor_row_reg <= 5'(row_reg);
            cursor_col_reg <= 7'(col_reg);
            if ((cmd_reg == CMD_READ) && rok_reg)
            begin
                cell_char_reg <= rd_data_reg[7:0];
                cell_attr_reg <= rd_data_reg[15:8];
            end
            else
            begin
                cell_char_reg <= '0;
                cell_attr_reg <= '0;
            end
        end
    end

    // status to the controller
    always_comb
    begin
        stat.is_put      = (cmd_reg == CMD_PUT);
        stat.is_clear    = (cmd_reg == CMD_CLEAR);
        stat.is_read     = (cmd_reg == CMD_READ);
        stat.is_nl       = (char_reg == CH_NEWLINE);
        stat.is_cr       = (char_reg == CH_RETURN);
        stat.is_tab      = (char_reg == CH_TAB);
        stat.is_bs       = (char_reg == CH_BACKSPACE);
        stat.is_hook     = (char_reg == CH_NUL) || (char_reg == CH_SHIFT_IN) ||
                           (char_reg == CH_GRAVE) || (char_reg == CH_TILDE);
        stat.col_zero    = (col_reg == '0);
        stat.last_row    = (row_reg == ROW_W'(ROWS - 1));
        stat.last_col    = (col_reg == COL_W'(COLS - 1));
        stat.tab_more    = (tab_cnt_reg > 5'd1);
        stat.sweep_last  = (cnt_reg == ADDR_W'(NCELLS - 1));
        stat.scroll_last = (cnt_reg == ADDR_W'(COLS - 1));
    end

    assign cursor_row = cursor_row_reg;
    assign cursor_col = cursor_col_reg;
    assign cell_char  = cell_char_reg;
    assign cell_attr  = cell_attr_reg;

endmodule

`default_nettype wire

// ----- rtl/text_console_writer.sv -----
// Text console writer: a ROWS x COLS store of character cells and a cursor.
// Input channel (in_valid / in_stall) carries one command word: put a
// character at the cursor, clear the screen, or read one cell. Each word
// gives exactly one result word on the output channel (out_valid /
// out_stall): the cursor after the command and, for a read, the cell.
// Configuration (fg_color, bg_color, tab_size) is written through cfg_we /
// cfg_index / cfg_data; the user is to write it only while the block is
// idle, and the block itself does not enforce this.
// Each scroll blanks the row that leaves the top, one cell per cycle (rows
// are never moved); clear blanks one cell per cycle through the single-port
// store.
// One word is in work at a time; a new word is taken once the last one has
// reached the result register.
// After reset the store is swept to blank light grey on black, and in_stall
// stays high during the sweep.
// A stalled result holds in its register; the block finishes the next
// word and then waits for the register to free up.
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [4:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] command,
    input  wire logic [7:0] char_code,
    input  wire logic       fg_override_on,
    input  wire logic [3:0] fg_override,
    input  wire logic [4:0] read_row,
    input  wire logic [6:0] read_col,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [4:0]      cursor_row,
    output logic [6:0]      cursor_col,
    output logic [7:0]      cell_char,
    output logic [7:0]      cell_attr
);

    tcw_ctl_t  ctl;
    tcw_stat_t stat;

    // sequencer
    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    // cell store, cursor and result register
    tcw_datapath #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .command        (command),
        .char_code      (char_code),
        .fg_override_on (fg_override_on),
        .fg_override    (fg_override),
        .read_row       (read_row),
        .read_col       (read_col),
        .ctl            (ctl),
        .stat           (stat),
        .cursor_row     (cursor_row),
        .cursor_col     (cursor_col),
        .cell_char      (cell_char),
        .cell_attr      (cell_attr)
    );

endmodule

`default_nettype wire

// ----- rtl/tcw_checker.sv -----
`default_nettype none

module tcw_checker
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
)
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [4:0] cursor_row,
    input wire logic [6:0] cursor_col,
    input wire logic [7:0] cell_char,
    input wire logic [7:0] cell_attr
);

    // a stalled result word stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // a stalled result word holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(cursor_row) && $stable(cursor_col) &&
                                   $stable(cell_char) && $stable(cell_attr))
        else $error("result word changed while stalled");

    // one word in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word taken while one is in work");

    // the reported cursor always lies on the screen
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({27'd0, cursor_row} < 32'(ROWS)) &&
                      ({25'd0, cursor_col} < 32'(COLS)))
        else $error("cursor off the screen");

endmodule

bind text_console_writer tcw_checker #(
    .COLS (COLS),
    .ROWS (ROWS)
) u_tcw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col),
    .cell_char  (cell_char),
    .cell_attr  (cell_attr)
);

`default_nettype wire

// ----- tb/text_console_checker.sv -----
`timescale 1ns / 1ps

module text_console_checker
    import tcw_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [4:0] cfg_data,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [1:0] command,
    input  logic [7:0] char_code,
    input  logic       fg_override_on,
    input  logic [3:0] fg_override,
    input  logic [4:0] read_row,
    input  logic [6:0] read_col,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [4:0] cursor_row,
    input  logic [6:0] cursor_col,
    input  logic [7:0] cell_char,
    input  logic [7:0] cell_attr,
    output int         failures,
    output int         replies_pending,
    output int         replies_checked,
    output int         scrolls_seen
);

    typedef struct packed {
        logic [4:0] row;
        logic [6:0] col;
        logic [7:0] ch;
        logic [7:0] attr;
    } console_reply_t;

    // shadow of the screen, cursor and colour registers
    logic [15:0]    screen [ROWS*COLS];
    int unsigned    cur_row;
    int unsigned    cur_col;
    logic [3:0]     fg_reg;
    logic [3:0]     bg_reg;
    logic [4:0]     tab_reg;
    console_reply_t replies_due [$];

    function automatic logic [15:0] blank_of(input logic [7:0] attr);
        return {attr, CH_BLANK};
    endfunction

    // cursor fell below the last row: move every row up, blank the bottom one
    function automatic void scroll_if_below(input logic [7:0] attr);
        int i;
        if (cur_row >= ROWS)
        begin
            for (i = 0; i < (ROWS - 1) * COLS; i++)
                screen[i] = screen[i + COLS];
            for (i = (ROWS - 1) * COLS; i < ROWS * COLS; i++)
                screen[i] = blank_of(attr);
            cur_row = ROWS - 1;
            scrolls_seen++;
        end
    endfunction

    function automatic void step_cursor(input logic [7:0] attr);
        cur_col++;
        if (cur_col >= COLS)
        begin
            cur_col = 0;
            cur_row++;
        end
        scroll_if_below(attr);
    endfunction

    function automatic void put_here(input logic [7:0] ch, input logic [7:0] attr);
        screen[cur_row * COLS + cur_col] = {attr, ch};
    endfunction

    // applies one command word to the shadow and returns the reply it causes
    function automatic console_reply_t compute_console_reply(
        input logic [1:0] cmd,
        input logic [7:0] ch,
        input logic       ovr_on,
        input logic [3:0] ovr_fg,
        input logic [4:0] rr,
        input logic [6:0] rc
    );
        console_reply_t reply;
        logic [7:0]     attr;
        int             i;
        reply = '0;
        attr  = {bg_reg, ovr_on ? ovr_fg : fg_reg};
        case (cmd)
            CMD_PUT:
            begin
                case (ch)
                    CH_NEWLINE:
                    begin
                        cur_col = 0;
                        cur_row++;
                        scroll_if_below(attr);
                    end
                    CH_RETURN:
                        cur_col = 0;
                    CH_TAB:
                    begin
                        // a size of zero still gives the one final step
                        for (i = 1; i < tab_reg; i++)
                        begin
                            put_here(CH_BLANK, attr);
                            step_cursor(attr);
                        end
                        step_cursor(attr);
                    end
                    CH_BACKSPACE:
                    begin
                        if (cur_col > 0)
                        begin
                            cur_col--;
                            put_here(CH_BLANK, attr);
                        end
                    end
                    CH_NUL, CH_SHIFT_IN, CH_GRAVE, CH_TILDE:
                        step_cursor(attr);
                    default:
                    begin
                        put_here(ch, attr);
                        step_cursor(attr);
                    end
                endcase
            end
            CMD_CLEAR:
            begin
                // the per-character override plays no part here
                for (i = 0; i < ROWS * COLS; i++)
                    screen[i] = blank_of({bg_reg, fg_reg});
                cur_row = 0;
                cur_col = 0;
            end
            CMD_READ:
            begin
                if (rr < ROWS && rc < COLS)
                    {reply.attr, reply.ch} = screen[rr * COLS + rc];
            end
            default:
                ;
        endcase
        reply.row = cur_row[4:0];
        reply.col = cur_col[6:0];
        return reply;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            failures++;
            $error("%s: expected %0d, got %0d", field, want, got);
        end
    endtask

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        console_reply_t want;
        int             i;
        if (!rst_n)
        begin
            for (i = 0; i < ROWS * COLS; i++)
                screen[i] = blank_of({BG_DEFAULT, FG_DEFAULT});
            cur_row         = 0;
            cur_col         = 0;
            fg_reg          = FG_DEFAULT;
            bg_reg          = BG_DEFAULT;
            tab_reg         = TAB_DEFAULT;
            failures        = 0;
            replies_pending = 0;
            replies_checked = 0;
            scrolls_seen    = 0;
            replies_due.delete();
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FG:  fg_reg  = cfg_data[3:0];
                    CFG_BG:  bg_reg  = cfg_data[3:0];
                    CFG_TAB: tab_reg = cfg_data;
                    default: ;
                endcase
            end

            // result words against the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (replies_due.size() == 0)
                begin
                    failures++;
                    $error("result word with nothing outstanding: row %0d col %0d",
                           cursor_row, cursor_col);
                end
                else
                begin
                    want = replies_due.pop_front();
                    check_field("cursor_row", want.row, cursor_row);
                    check_field("cursor_col", want.col, cursor_col);
                    check_field("cell_char", want.ch, cell_char);
                    check_field("cell_attr", want.attr, cell_attr);
                    replies_checked++;
                end
            end

            // command words into the shadow
            if (in_valid && !in_stall)
                replies_due.push_back(compute_console_reply(command, char_code,
                    fg_override_on, fg_override, read_row, read_col));

            replies_pending = replies_due.size();
        end
    end

endmodule

// ----- tb/tb_text_console_writer.sv -----
`timescale 1ns / 1ps

module tb_text_console_writer;
    import tcw_pkg::*;

    localparam int         COLS            = 80;
    localparam int         ROWS            = 25;
    localparam logic [1:0] CMD_NONE        = 2'd3;
    localparam logic [1:0] CFG_NONE        = 2'd3;
    localparam int         WATCHDOG_LIMIT  = 20000;
    localparam int         HOLD_OFF_CYCLES = 400;
    localparam int         PHASE_WORDS     = 204;
    localparam int         SETTLE_CYCLES   = 20;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [4:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] command;
    logic [7:0] char_code;
    logic       fg_override_on;
    logic [3:0] fg_override;
    logic [4:0] read_row;
    logic [6:0] read_col;
    logic       out_valid;
    logic       out_stall;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;

    int failures;
    int replies_pending;
    int replies_checked;
    int scrolls_seen;

    int words_sent;
    int puts_sent;
    int reads_sent;
    int clears_sent;
    int odd_sent;
    int settings_used;
    bit hold_off_req;
    bit hold_off_done;
    bit long_lines;

    text_console_writer #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .char_code      (char_code),
        .fg_override_on (fg_override_on),
        .fg_override    (fg_override),
        .read_row       (read_row),
        .read_col       (read_col),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cursor_row     (cursor_row),
        .cursor_col     (cursor_col),
        .cell_char      (cell_char),
        .cell_attr      (cell_attr)
    );

    text_console_checker #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .char_code       (char_code),
        .fg_override_on  (fg_override_on),
        .fg_override     (fg_override),
        .read_row        (read_row),
        .read_col        (read_col),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .cursor_row      (cursor_row),
        .cursor_col      (cursor_col),
        .cell_char       (cell_char),
        .cell_attr       (cell_attr),
        .failures        (failures),
        .replies_pending (replies_pending),
        .replies_checked (replies_checked),
        .scrolls_seen    (scrolls_seen)
    );

    // 100 MHz clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // give up after a long stretch with no word moving on either channel
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
    end

    // result side back-pressure, with one long hold-off on request
    initial
    begin : receiver
        int pick;
        int len;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !hold_off_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                out_stall     <= 1'b0;
                hold_off_done = 1'b1;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    out_stall <= 1'b0;
                    len = $urandom_range(1, 24);
                end
                else if (pick < 88)
                begin
                    out_stall <= 1'b1;
                    len = $urandom_range(1, 3);
                end
                else if (pick < 98)
                begin
                    out_stall <= 1'b1;
                    len = $urandom_range(4, 20);
                end
                else
                begin
                    out_stall <= 1'b1;
                    len = $urandom_range(30, 80);
                end
                repeat (len - 1) @(negedge clk);
            end
        end
    end

    // idle cycles before the next word, none while the receiver holds off
    function automatic int pick_sender_gap();
        int pick;
        if (hold_off_req && !hold_off_done)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        else if (pick < 85)
            return $urandom_range(1, 3);
        else if (pick < 97)
            return $urandom_range(4, 15);
        else
            return $urandom_range(20, 60);
    endfunction

    // offer one command word and hold it until it is taken
    task automatic send_word(
        input logic [1:0] cmd,
        input logic [7:0] ch,
        input logic       ovr_on,
        input logic [3:0] ovr_fg,
        input logic [4:0] rr,
        input logic [6:0] rc
    );
        int gap;
        gap = pick_sender_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        command        <= cmd;
        char_code      <= ch;
        fg_override_on <= ovr_on;
        fg_override    <= ovr_fg;
        read_row       <= rr;
        read_col       <= rc;
        in_valid       <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        case (cmd)
            CMD_PUT:   puts_sent++;
            CMD_READ:  reads_sent++;
            CMD_CLEAR: clears_sent++;
            default:   odd_sent++;
        endcase
    endtask

    // random word: mostly text with control characters, some reads
    task automatic send_random_word();
        logic [1:0] cmd;
        logic [7:0] ch;
        logic [4:0] rr;
        logic [6:0] rc;
        int         pick;
        ch   = 8'($urandom_range(0, 255));
        rr   = 5'($urandom_range(0, ROWS - 1));
        rc   = 7'($urandom_range(0, COLS - 1));
        pick = $urandom_range(0, 999);
        if (pick < 3)
            cmd = CMD_CLEAR;
        else if (pick < 15)
            cmd = CMD_NONE;
        else if (pick < 225)
        begin
            cmd = CMD_READ;
            if (pick < 45)
            begin
                // anywhere the fields reach, off-screen included
                rr = 5'($urandom_range(0, 31));
                rc = 7'($urandom_range(0, 127));
            end
            else if (pick < 135)
                rr = 5'($urandom_range(ROWS - 5, ROWS - 1));
        end
        else
        begin
            cmd  = CMD_PUT;
            pick = $urandom_range(0, 99);
            if (long_lines)
            begin
                // few line breaks so that lines wrap
                if (pick < 1)
                    ch = CH_NEWLINE;
                else if (pick < 2)
                    ch = CH_RETURN;
                else if (pick < 10)
                    ch = CH_TAB;
                else if (pick < 13)
                    ch = CH_BACKSPACE;
            end
            else
            begin
                if (pick < 12)
                    ch = CH_NEWLINE;
                else if (pick < 16)
                    ch = CH_RETURN;
                else if (pick < 24)
                    ch = CH_TAB;
                else if (pick < 32)
                    ch = CH_BACKSPACE;
                else if (pick < 38)
                begin
                    case (pick % 4)
                        0:       ch = CH_NUL;
                        1:       ch = CH_SHIFT_IN;
                        2:       ch = CH_GRAVE;
                        default: ch = CH_TILDE;
                    endcase
                end
            end
        end
        send_word(cmd, ch, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), rr, rc);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [4:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_until_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (replies_pending == 0);
        repeat (4) @(negedge clk);
    endtask

    // new colour and tab setting, then a batch of random words
    task automatic run_phase(
        input logic [4:0] fg_data,
        input logic [4:0] bg_data,
        input logic [4:0] tab_data,
        input bit         spare_write,
        input bit         with_hold_off,
        input bit         wrap_heavy
    );
        int n;
        wait_until_idle();
        write_reg(CFG_FG, fg_data);
        write_reg(CFG_BG, bg_data);
        write_reg(CFG_TAB, tab_data);
        if (spare_write)
            write_reg(CFG_NONE, 5'($urandom_range(0, 31)));
        settings_used++;
        long_lines = wrap_heavy;
        for (n = 0; n < PHASE_WORDS; n++)
        begin
            if (with_hold_off && n == PHASE_WORDS / 3)
                hold_off_req = 1'b1;
            send_random_word();
        end
    endtask

    initial
    begin : stimulus
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_FG;
        cfg_data       = '0;
        in_valid       = 1'b0;
        command        = CMD_PUT;
        char_code      = '0;
        fg_override_on = 1'b0;
        fg_override    = '0;
        read_row       = '0;
        read_col       = '0;
        words_sent     = 0;
        puts_sent      = 0;
        reads_sent     = 0;
        clears_sent    = 0;
        odd_sent       = 0;
        settings_used  = 1;
        hold_off_req   = 1'b0;
        hold_off_done  = 1'b0;
        long_lines     = 1'b0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed words under the reset colours and tab size
        send_word(CMD_READ, 8'h00, 1'b0, 4'd0, 5'd0, 7'd0);
        send_word(CMD_READ, 8'h00, 1'b0, 4'd0, 5'(ROWS - 1), 7'(COLS - 1));
        send_word(CMD_PUT, 8'h41, 1'b0, 4'd0, 5'd0, 7'd0);
        send_word(CMD_PUT, 8'hFF, 1'b1, 4'hF, 5'd0, 7'd0);
        send_word(CMD_PUT, 8'h80, 1'b1, 4'h0, 5'd0, 7'd0);
        send_word(CMD_PUT, CH_BACKSPACE, 1'b1, 4'h5, 5'd0, 7'd0);
        send_word(CMD_PUT, CH_TAB, 1'b0, 4'd0, 5'd0, 7'd0);
        send_word(CMD_PUT, CH_NUL, 1'b0, 4'd0, 5'd0, 7'd0);
        send_word(CMD_PUT, CH_SHIFT_IN, 1'b0, 4'd0, 5'd0, 7'd0);
        send_word(CMD_PUT, CH_GRAVE, 1'b0, 4'd0, 5'd0, 7'd0);
        send_word(CMD_PUT, CH_TILDE, 1'b0, 4'd0, 5'd0, 7'd0);
        send_word(CMD_PUT, CH_RETURN, 1'b0, 4'd0, 5'd0, 7'd0);
        // backspace at column zero leaves everything alone
        send_word(CMD_PUT, CH_BACKSPACE, 1'b0, 4'd0, 5'd0, 7'd0);
        send_word(CMD_PUT, CH_NEWLINE, 1'b0, 4'd0, 5'd0, 7'd0);
        send_word(CMD_PUT, 8'h7F, 1'b1, 4'hA, 5'd0, 7'd0);
        send_word(CMD_READ, 8'h00, 1'b0, 4'd0, 5'd0, 7'd0);
        send_word(CMD_READ, 8'h00, 1'b0, 4'd0, 5'd0, 7'd1);
        // reads off the screen return zeros
        send_word(CMD_READ, 8'h00, 1'b0, 4'd0, 5'(ROWS), 7'd0);
        send_word(CMD_READ, 8'h00, 1'b0, 4'd0, 5'h1F, 7'h7F);
        send_word(CMD_READ, 8'h00, 1'b0, 4'd0, 5'd0, 7'(COLS));
        send_word(CMD_NONE, 8'h41, 1'b1, 4'hF, 5'd1, 7'd0);
        send_word(CMD_READ, 8'h00, 1'b0, 4'd0, 5'd1, 7'd0);
        send_word(CMD_CLEAR, 8'h00, 1'b1, 4'hC, 5'd0, 7'd0);
        send_word(CMD_READ, 8'h00, 1'b0, 4'd0, 5'd0, 7'd1);
        send_word(CMD_PUT, 8'h5A, 1'b0, 4'd0, 5'd0, 7'd0);

        // random words over a spread of settings, extremes first
        run_phase(5'h1F, 5'h1F, 5'd16, 1'b0, 1'b1, 1'b0);
        run_phase(5'h00, 5'h00, 5'd1, 1'b0, 1'b0, 1'b1);
        run_phase(5'd9, 5'd5, 5'd0, 1'b0, 1'b0, 1'b0);
        run_phase(5'd3, 5'd12, 5'h1F, 1'b0, 1'b0, 1'b1);
        run_phase(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                  5'($urandom_range(1, 16)), 1'b1, 1'b0, 1'b0);
        run_phase({1'b0, FG_DEFAULT}, {1'b0, BG_DEFAULT}, TAB_DEFAULT,
                  1'b0, 1'b0, 1'b1);
        run_phase(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                  5'($urandom_range(0, 31)), 1'b0, 1'b0, 1'b0);

        wait_until_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d words: %0d puts, %0d reads, %0d clears, %0d unused codes",
                 words_sent, puts_sent, reads_sent, clears_sent, odd_sent);
        $display("%0d settings, %0d results compared, %0d scrolls, one %0d-cycle hold-off",
                 settings_used, replies_checked, scrolls_seen, HOLD_OFF_CYCLES);
        if (failures == 0 && replies_pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/tcw_pkg.sv
rtl/tcw_ctrl.sv
rtl/tcw_datapath.sv
rtl/text_console_writer.sv
rtl/tcw_checker.sv
tb/text_console_checker.sv
tb/tb_text_console_writer.sv
